// ----- sv/qrm_pkg.sv -----
// Shared widths, latencies and stage structs for the quaternion to rotation matrix pipeline.
package qrm_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int MAG_W     = IN_W;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int Q_W       = FRAC_BITS + 2;
    localparam int N_ENT     = 9;
    localparam int N_DIV_ST  = FRAC_BITS + 2;
    localparam int FRONT_LAT = 3;
    localparam int PIPE_LAT  = FRONT_LAT + N_DIV_ST + 1;

    // The value 1.0 at the quotient width.
    localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;

    // Numerators and the common denominator leaving the front end.
    typedef struct packed {
        logic                             vld;
        logic                             zero;
        logic [SUM_W-1:0]                 s;
        logic [N_ENT-1:0][SUM_W-1:0]      n;
        logic [N_ENT-1:0]                 neg;
    } t_frac;

    // Raw quotients leaving the divider.
    typedef struct packed {
        logic                             vld;
        logic                             zero;
        logic [N_ENT-1:0][Q_W-1:0]        q;
        logic [N_ENT-1:0]                 neg;
    } t_quo;

endpackage

// ----- sv/qrm_front.sv -----
// Front end: magnitudes, squares and products, then denominator and numerators.
module qrm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [qrm_pkg::IN_W-1:0]      i_x,
    input  logic [qrm_pkg::IN_W-1:0]      i_y,
    input  logic [qrm_pkg::IN_W-1:0]      i_z,
    input  logic [qrm_pkg::IN_W-1:0]      i_w,
    output qrm_pkg::t_frac                o_frac
);

    typedef struct packed {
        logic                        neg;
        logic [qrm_pkg::SUM_W-1:0]   mag;
    } t_sm;

    // Signed-magnitude sum of two products, doubled.
    function automatic t_sm sm_dbl(input logic sa, input logic [qrm_pkg::PROD_W-1:0] ma,
                                   input logic sb, input logic [qrm_pkg::PROD_W-1:0] mb);
        t_sm                       res;
        logic [qrm_pkg::SUM_W-1:0] mo;
        logic                      so;
        if (sa == sb) begin
            so = sa;
            mo = qrm_pkg::SUM_W'(ma) + qrm_pkg::SUM_W'(mb);
        end else if (ma >= mb) begin
            so = sa;
            mo = qrm_pkg::SUM_W'(ma - mb);
        end else begin
            so = sb;
            mo = qrm_pkg::SUM_W'(mb - ma);
        end
        res.neg = so && (mo != '0);
        res.mag = mo << 1;
        return res;
    endfunction

    function automatic t_sm diag(input logic [qrm_pkg::SUM_W-1:0] p,
                                 input logic [qrm_pkg::SUM_W-1:0] m);
        t_sm res;
        if (p >= m) begin
            res.neg = 1'b0;
            res.mag = p - m;
        end else begin
            res.neg = 1'b1;
            res.mag = m - p;
        end
        return res;
    endfunction

    logic [qrm_pkg::IN_W-1:0]   comp [4];
    logic [qrm_pkg::MAG_W-1:0]  mag_raw [4];
    logic                       all_even;

    logic                       r_vld1;
    logic [qrm_pkg::MAG_W-1:0]  r_mag [4];
    logic [3:0]                 r_neg1;

    logic                       r_vld2;
    logic [qrm_pkg::PROD_W-1:0] r_sq [4];
    logic [qrm_pkg::PROD_W-1:0] r_pr [6];
    logic [3:0]                 r_neg2;

    qrm_pkg::t_frac             n_out;
    qrm_pkg::t_frac             r_out;
    t_sm                        ent [qrm_pkg::N_ENT];

    assign comp[0] = i_x;
    assign comp[1] = i_y;
    assign comp[2] = i_z;
    assign comp[3] = i_w;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mag_raw[i] = comp[i][qrm_pkg::IN_W-1] ? (~comp[i] + 1'b1) : comp[i];
        end
        all_even = ~(mag_raw[0][0] | mag_raw[1][0] | mag_raw[2][0] | mag_raw[3][0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_mag[i]  <= all_even ? (mag_raw[i] >> 1) : mag_raw[i];
            r_neg1[i] <= comp[i][qrm_pkg::IN_W-1];
            r_sq[i]   <= r_mag[i] * r_mag[i];
        end
        r_pr[0] <= r_mag[0] * r_mag[1];
        r_pr[1] <= r_mag[0] * r_mag[2];
        r_pr[2] <= r_mag[1] * r_mag[2];
        r_pr[3] <= r_mag[0] * r_mag[3];
        r_pr[4] <= r_mag[1] * r_mag[3];
        r_pr[5] <= r_mag[2] * r_mag[3];
        r_neg2  <= r_neg1;
    end

    // Products: 0 xy, 1 xz, 2 yz, 3 xw, 4 yw, 5 zw.
    always_comb begin
        ent[0] = diag(qrm_pkg::SUM_W'(r_sq[0]) + qrm_pkg::SUM_W'(r_sq[3]),
                      qrm_pkg::SUM_W'(r_sq[1]) + qrm_pkg::SUM_W'(r_sq[2]));
        ent[4] = diag(qrm_pkg::SUM_W'(r_sq[1]) + qrm_pkg::SUM_W'(r_sq[3]),
                      qrm_pkg::SUM_W'(r_sq[0]) + qrm_pkg::SUM_W'(r_sq[2]));
        ent[8] = diag(qrm_pkg::SUM_W'(r_sq[2]) + qrm_pkg::SUM_W'(r_sq[3]),
                      qrm_pkg::SUM_W'(r_sq[0]) + qrm_pkg::SUM_W'(r_sq[1]));
        ent[1] = sm_dbl(r_neg2[0] ^ r_neg2[1], r_pr[0], ~(r_neg2[2] ^ r_neg2[3]), r_pr[5]);
        ent[3] = sm_dbl(r_neg2[0] ^ r_neg2[1], r_pr[0],   r_neg2[2] ^ r_neg2[3],  r_pr[5]);
        ent[2] = sm_dbl(r_neg2[0] ^ r_neg2[2], r_pr[1],   r_neg2[1] ^ r_neg2[3],  r_pr[4]);
        ent[6] = sm_dbl(r_neg2[0] ^ r_neg2[2], r_pr[1], ~(r_neg2[1] ^ r_neg2[3]), r_pr[4]);
        ent[5] = sm_dbl(r_neg2[1] ^ r_neg2[2], r_pr[2], ~(r_neg2[0] ^ r_neg2[3]), r_pr[3]);
        ent[7] = sm_dbl(r_neg2[1] ^ r_neg2[2], r_pr[2],   r_neg2[0] ^ r_neg2[3],  r_pr[3]);

        n_out     = '0;
        n_out.vld = r_vld2;
        n_out.s   = qrm_pkg::SUM_W'(r_sq[0]) + qrm_pkg::SUM_W'(r_sq[1])
                  + qrm_pkg::SUM_W'(r_sq[2]) + qrm_pkg::SUM_W'(r_sq[3]);
        n_out.zero = (n_out.s == '0);
        for (int e = 0; e < qrm_pkg::N_ENT; e++) begin
            n_out.n[e]   = ent[e].mag;
            n_out.neg[e] = ent[e].neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.vld <= 1'b0;
        end else begin
            r_out.vld <= n_out.vld;
        end
        r_out.zero <= n_out.zero;
        r_out.s    <= n_out.s;
        r_out.n    <= n_out.n;
        r_out.neg  <= n_out.neg;
    end

    assign o_frac = r_out;

endmodule

// ----- sv/qrm_div.sv -----
// Pipelined restoring divider: one quotient bit per stage for all nine entries.
module qrm_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  qrm_pkg::t_frac  i_frac,
    output qrm_pkg::t_quo   o_quo
);

    typedef struct packed {
        logic                                             zero;
        logic [qrm_pkg::SUM_W-1:0]                        s;
        logic [qrm_pkg::N_ENT-1:0][qrm_pkg::SUM_W-1:0]    r;
        logic [qrm_pkg::N_ENT-1:0][qrm_pkg::Q_W-1:0]      q;
        logic [qrm_pkg::N_ENT-1:0]                        neg;
    } t_dst;

    t_dst                            n_st [qrm_pkg::N_DIV_ST];
    t_dst                            r_st [qrm_pkg::N_DIV_ST];
    logic [qrm_pkg::N_DIV_ST-1:0]    r_vld;

    always_comb begin
        logic [qrm_pkg::SUM_W:0] two_r;
        two_r = '0;
        // The first stage takes the integer bit; every later stage one fraction bit.
        n_st[0].zero = i_frac.zero;
        n_st[0].s    = i_frac.s;
        n_st[0].neg  = i_frac.neg;
        for (int e = 0; e < qrm_pkg::N_ENT; e++) begin
            if (i_frac.n[e] >= i_frac.s) begin
                n_st[0].r[e] = i_frac.n[e] - i_frac.s;
                n_st[0].q[e] = qrm_pkg::Q_W'(1);
            end else begin
                n_st[0].r[e] = i_frac.n[e];
                n_st[0].q[e] = '0;
            end
        end
        for (int j = 1; j < qrm_pkg::N_DIV_ST; j++) begin
            n_st[j].zero = r_st[j-1].zero;
            n_st[j].s    = r_st[j-1].s;
            n_st[j].neg  = r_st[j-1].neg;
            for (int e = 0; e < qrm_pkg::N_ENT; e++) begin
                two_r = {r_st[j-1].r[e], 1'b0};
                if (two_r >= {1'b0, r_st[j-1].s}) begin
                    n_st[j].r[e] = qrm_pkg::SUM_W'(two_r - {1'b0, r_st[j-1].s});
                    n_st[j].q[e] = {r_st[j-1].q[e][qrm_pkg::Q_W-2:0], 1'b1};
                end else begin
                    n_st[j].r[e] = qrm_pkg::SUM_W'(two_r);
                    n_st[j].q[e] = {r_st[j-1].q[e][qrm_pkg::Q_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[qrm_pkg::N_DIV_ST-2:0], i_frac.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < qrm_pkg::N_DIV_ST; j++) begin
            r_st[j] <= n_st[j];
        end
    end

    assign o_quo.vld  = r_vld[qrm_pkg::N_DIV_ST-1];
    assign o_quo.zero = r_st[qrm_pkg::N_DIV_ST-1].zero;
    assign o_quo.q    = r_st[qrm_pkg::N_DIV_ST-1].q;
    assign o_quo.neg  = r_st[qrm_pkg::N_DIV_ST-1].neg;

endmodule

// ----- sv/qrm_out.sv -----
// Output stage: rounding, clamping, sign and the identity case, registered.
module qrm_out (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  qrm_pkg::t_quo                                   i_quo,
    output logic                                            o_vld,
    output logic [qrm_pkg::N_ENT-1:0][qrm_pkg::OUT_W-1:0]   o_rot
);

    logic                                            r_vld;
    logic [qrm_pkg::N_ENT-1:0][qrm_pkg::OUT_W-1:0]   r_rot;
    logic [qrm_pkg::N_ENT-1:0][qrm_pkg::OUT_W-1:0]   n_rot;

    always_comb begin
        logic [qrm_pkg::Q_W:0]     qp1;
        logic [qrm_pkg::Q_W-1:0]   res;
        logic [qrm_pkg::OUT_W-1:0] mag;
        qp1 = '0;
        res = '0;
        mag = '0;
        for (int e = 0; e < qrm_pkg::N_ENT; e++) begin
            qp1 = {1'b0, i_quo.q[e]} + 1'b1;
            res = qrm_pkg::Q_W'(qp1 >> 1);
            if (res > qrm_pkg::ONE_Q) begin
                res = qrm_pkg::ONE_Q;
            end
            mag = qrm_pkg::OUT_W'(res);
            if (i_quo.zero) begin
                n_rot[e] = (e % 4 == 0) ? qrm_pkg::OUT_W'(qrm_pkg::ONE_Q) : '0;
            end else if (i_quo.neg[e] && (mag != '0)) begin
                n_rot[e] = ~mag + 1'b1;
            end else begin
                n_rot[e] = mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_quo.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rot <= n_rot;
    end

    assign o_vld = r_vld;
    assign o_rot = r_rot;

endmodule

// ----- sv/quaternion_to_rotation_matrix_unit.sv -----
// Top level: quaternion to 3x3 rotation matrix in Q1.14, fully pipelined.
//
// Feed one quaternion (x, y, z, w), signed 16-bit at any common scale, with start;
// busy is always low, so a new beat can be sent on every clock. For each beat taken,
// o_valid is high for one cycle with the nine matrix entries of the normalized
// quaternion in Q1.14 (16384 is 1.0), rounded to nearest with ties away from zero
// and clamped to [-1, 1]. The pipeline is built from the three front-end stages
// (magnitudes, products, numerators), the sixteen stages of the divider that
// produce one quotient bit each, and the output register. Results
// cannot be held off: the receiver must take each beat in the cycle it appears.
// A zero quaternion gives the identity matrix.
module quaternion_to_rotation_matrix_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [qrm_pkg::IN_W-1:0]  i_quat_x,
    input  logic signed [qrm_pkg::IN_W-1:0]  i_quat_y,
    input  logic signed [qrm_pkg::IN_W-1:0]  i_quat_z,
    input  logic signed [qrm_pkg::IN_W-1:0]  i_quat_w,
    output logic                             o_valid,
    output logic signed [qrm_pkg::OUT_W-1:0] o_rot_00,
    output logic signed [qrm_pkg::OUT_W-1:0] o_rot_01,
    output logic signed [qrm_pkg::OUT_W-1:0] o_rot_02,
    output logic signed [qrm_pkg::OUT_W-1:0] o_rot_10,
    output logic signed [qrm_pkg::OUT_W-1:0] o_rot_11,
    output logic signed [qrm_pkg::OUT_W-1:0] o_rot_12,
    output logic signed [qrm_pkg::OUT_W-1:0] o_rot_20,
    output logic signed [qrm_pkg::OUT_W-1:0] o_rot_21,
    output logic signed [qrm_pkg::OUT_W-1:0] o_rot_22
);

    qrm_pkg::t_frac                                   frac;
    qrm_pkg::t_quo                                    quo;
    logic [qrm_pkg::N_ENT-1:0][qrm_pkg::OUT_W-1:0]    rot;

    // The pipeline never stalls, so every start is taken.
    assign busy = 1'b0;

    // Sign handling, squares, cross products and the numerators of all nine entries.
    qrm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_x     (i_quat_x),
        .i_y     (i_quat_y),
        .i_z     (i_quat_z),
        .i_w     (i_quat_w),
        .o_frac  (frac)
    );

    // Nine restoring dividers share the denominator as it travels down the stages.
    qrm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frac  (frac),
        .o_quo   (quo)
    );

    qrm_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quo   (quo),
        .o_vld   (o_valid),
        .o_rot   (rot)
    );

    assign o_rot_00 = rot[0];
    assign o_rot_01 = rot[1];
    assign o_rot_02 = rot[2];
    assign o_rot_10 = rot[3];
    assign o_rot_11 = rot[4];
    assign o_rot_12 = rot[5];
    assign o_rot_20 = rot[6];
    assign o_rot_21 = rot[7];
    assign o_rot_22 = rot[8];

    // Every accepted beat comes out after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(qrm_pkg::PIPE_LAT) o_valid)
        else $error("result beat missing after pipeline latency");

    // A zero quaternion yields the identity matrix.
    a_zero_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_quat_x == '0 && i_quat_y == '0 && i_quat_z == '0 && i_quat_w == '0)
        |-> ##(qrm_pkg::PIPE_LAT)
        (o_rot_00 == 16'sd16384 && o_rot_11 == 16'sd16384 && o_rot_22 == 16'sd16384
         && o_rot_01 == '0 && o_rot_12 == '0 && o_rot_20 == '0))
        else $error("zero quaternion did not give identity");

    // A pure x rotation of any nonzero scale keeps rot_00 at exactly one.
    a_pure_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_quat_x != '0 && i_quat_y == '0 && i_quat_z == '0 && i_quat_w == '0)
        |-> ##(qrm_pkg::PIPE_LAT) (o_rot_00 == 16'sd16384 && o_rot_01 == '0))
        else $error("pure x quaternion gave wrong first row");

endmodule
